// File: sv/phts_pkg.sv
package phts_pkg;

  // Table geometry: home slots from the low key bits, plus guard slots so that
  // a probe window starting at the last home slot stays inside the table.
  localparam int INDEX_BITS = 16;
  localparam int PROBES     = 8;
  localparam int SLOT_COUNT = (1 << INDEX_BITS) + PROBES;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int PROBE_BITS = $clog2(PROBES + 1);

  // Command queue between front and back end; depth must be a power of two.
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [0:0] {
    OP_STORE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef struct packed {
    logic [31:0] lock;
    logic [7:0]  depth;
    logic [15:0] value;
    logic [1:0]  color;
  } entry_t;

  typedef struct packed {
    op_t                  op;
    logic [SLOT_BITS-1:0] home;
    logic [31:0]          lock;
    logic [15:0]          value;
    logic [7:0]           depth;
    logic [1:0]           color;
    logic [15:0]          need;
  } cmd_t;

endpackage

// File: sv/phts_front.sv
module phts_front
  import phts_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         clearing,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic [0:0]   in_tuser,
  output logic         cmd_valid,
  input  logic         cmd_ready,
  output cmd_t         cmd
);

  cmd_t                 q_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 push;
  logic                 pop;
  cmd_t                 in_cmd;

  // Decode the transfer into a command; the home slot is the low key bits.
  always_comb begin
    in_cmd.op    = op_t'(in_tuser[0]);
    in_cmd.home  = SLOT_BITS'(in_tdata[INDEX_BITS-1:0]);
    in_cmd.lock  = in_tdata[63:32];
    in_cmd.value = in_tdata[79:64];
    in_cmd.depth = in_tdata[87:80];
    in_cmd.color = in_tdata[89:88];
    in_cmd.need  = in_tdata[105:90];
  end

  assign in_tready = !clearing && (count_r != QCNT_BITS'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_BITS'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// File: sv/phts_engine.sv
module phts_engine
  import phts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  depth_scale,
  output logic        clearing,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [0:0]  out_tuser
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_BITS-1:0]  addr_r, addr_nxt;
  logic [PROBE_BITS-1:0] probe_r, probe_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic [15:0]           res_val_r, res_val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [15:0]           out_val_r, out_val_nxt;

  entry_t                mem [SLOT_COUNT];
  entry_t                rd_data_r;
  entry_t                wr_data;
  logic                  we;

  logic                  lock_eq;
  logic                  color_eq;
  logic                  empty;
  logic                  last_probe;
  logic [15:0]           scaled;

  assign lock_eq    = (rd_data_r.lock == cmd_r.lock);
  assign color_eq   = (rd_data_r.color == cmd_r.color);
  assign empty      = (rd_data_r.lock == 32'd0);
  assign last_probe = (probe_r == PROBE_BITS'(PROBES - 1));
  assign scaled     = 16'(rd_data_r.depth) * 16'(depth_scale);

  assign clearing   = (state_r == S_CLEAR);
  assign cmd_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_ok_r;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    probe_nxt     = probe_r;
    cmd_nxt       = cmd_r;
    res_ok_nxt    = res_ok_r;
    res_val_nxt   = res_val_r;
    out_ok_nxt    = out_ok_r;
    out_val_nxt   = out_val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    we            = 1'b0;
    wr_data       = '0;

    case (state_r)
      S_CLEAR: begin
        we       = 1'b1;
        addr_nxt = addr_r + SLOT_BITS'(1);
        if (addr_r == SLOT_BITS'(SLOT_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          addr_nxt  = cmd.home;
          probe_nxt = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        res_ok_nxt  = 1'b0;
        res_val_nxt = '0;
        if (cmd_r.op == OP_STORE) begin
          wr_data = '{lock: cmd_r.lock, depth: cmd_r.depth,
                      value: cmd_r.value, color: cmd_r.color};
          if (empty || lock_eq) begin
            we         = 1'b1;
            res_ok_nxt = 1'b1;
            state_nxt  = S_DONE;
          end else if (last_probe) begin
            state_nxt = S_DONE;
          end
        end else begin
          if (lock_eq && color_eq) begin
            // Matching entry ends the walk; it hits only when deep enough.
            if (scaled >= cmd_r.need) begin
              res_ok_nxt  = 1'b1;
              res_val_nxt = rd_data_r.value;
            end
            state_nxt = S_DONE;
          end else if (empty || last_probe) begin
            state_nxt = S_DONE;
          end
        end
        if (state_nxt == S_EVAL) begin
          addr_nxt  = addr_r + SLOT_BITS'(1);
          probe_nxt = probe_r + PROBE_BITS'(1);
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_val_nxt   = res_val_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        addr_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      probe_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      probe_r     <= probe_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    res_ok_r  <= res_ok_nxt;
    res_val_r <= res_val_nxt;
    out_ok_r  <= out_ok_nxt;
    out_val_r <= out_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr_r] <= wr_data;
    end
    rd_data_r <= mem[addr_r];
  end

  a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_CLEAR && cmd_ready))
    else $error("command taken during clearing pass");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLEAR || (state_r == S_EVAL && cmd_r.op == OP_STORE)))
    else $error("table written outside clear or store");

  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ || state_r == S_EVAL) |->
      ((addr_r - cmd_r.home) < SLOT_BITS'(PROBES)))
    else $error("probe address left the probe window");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside completion state");

endmodule

// File: sv/probed_hash_table_store_lookup.sv
// Hash table with linear probing. Each input transfer is a store or a lookup
// on a table of (1 << INDEX_BITS) + PROBES entries, each holding a 32-bit
// lock, an 8-bit depth, a 16-bit value and a 2-bit colour; the low key bits
// pick the home slot and up to PROBES consecutive slots are visited. Every
// input transfer yields exactly one result transfer. After reset the block
// runs a clearing pass over all SLOT_COUNT entries (65544 at the default
// geometry), one entry per cycle, during which in_tready stays low;
// configuration writes are taken throughout. The single table port sets the
// rate: each visited slot passes through a read state and then an evaluate
// state, after an idle state that takes the command and before a done state
// that posts the result, so the engine finishes one operation before it takes
// the next. A two entry command queue in front lets new transfers be taken
// while the probe engine works and while a result waits for out_tready.
module probed_hash_table_store_lookup
  import phts_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Command stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, from bit 0: key[31:0], lock[63:32], value_in[79:64],
  // entry_depth[87:80], color[89:88], required_depth[105:90], zero fill.
  input  logic [111:0] in_tdata,
  // in_tuser: opcode[0] (0 store, 1 lookup).
  input  logic [0:0]   in_tuser,
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata: result_value[15:0].
  output logic [15:0]  out_tdata,
  // out_tuser: success[0].
  output logic [0:0]   out_tuser,
  // Depth scale register write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);

  logic [7:0] depth_scale_r;
  logic       clearing;
  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;

  // The scale register is always ready. It must be written only while no
  // transfer is in flight, so that a change never lands in the middle of a
  // lookup.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_scale_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      depth_scale_r <= cfg_data;
    end
  end

  // Front end: accepts transfers, decodes them and queues the commands.
  phts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Back end: clears the table after reset, then walks the probe window for
  // each command and holds the result in its output register.
  phts_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .depth_scale (depth_scale_r),
    .clearing    (clearing),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

// File: bench/testbench.sv
module testbench;
  import phts_pkg::*;

  // Cycles in which nothing at all is transferred before the run is given up.
  // No command or result is transferred during the clearing pass after reset.
  localparam int STALL_LIMIT = 4 * SLOT_COUNT;
  // Cycles allowed for the block to settle once every result has arrived.
  localparam int SETTLE_CYCLES = 40;
  // Length of the long receiver hold-off that fills the command queue.
  localparam int HOLD_CYCLES = 400;

  // One command as the sender sees it, and the result it should bring back.
  typedef struct {
    op_t         op;
    logic [31:0] key;
    logic [31:0] lock;
    logic [15:0] value;
    logic [7:0]  depth;
    logic [1:0]  color;
    logic [15:0] need;
  } command_t;

  typedef struct {
    logic        success;
    logic [15:0] value;
  } outcome_t;

  typedef struct {
    logic [31:0] lock;
    logic [7:0]  depth;
    logic [15:0] value;
    logic [1:0]  color;
  } slot_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data = '0;

  probed_hash_table_store_lookup i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the table and of the depth scale register.
  slot_t       shadow_table [SLOT_COUNT];
  logic [7:0]  shadow_scale = 8'd1;

  command_t    command_queue [$];
  outcome_t    awaited_results [$];
  logic [31:0] lock_pool [24];

  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_arm = 1'b0;
  logic        hold_used = 1'b0;
  logic        in_hs = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Store or look up one command against the shadow table. A store takes the
  // first slot of the window that is empty or already holds its lock. A lookup
  // stops on a lock and colour match, or on an empty slot, and otherwise walks
  // on; a match only hits when the scaled stored depth reaches the need.
  function automatic outcome_t probe_table(command_t c);
    outcome_t    r;
    int unsigned home;
    int unsigned s;
    logic        done;
    logic [31:0] scaled;
    r.success = 1'b0;
    r.value = '0;
    home = c.key[INDEX_BITS-1:0];
    done = 1'b0;
    for (int i = 0; i < PROBES && !done; i++) begin
      s = home + i;
      if (c.op == OP_STORE) begin
        if (shadow_table[s].lock == 32'd0 || shadow_table[s].lock == c.lock) begin
          shadow_table[s].lock = c.lock;
          shadow_table[s].depth = c.depth;
          shadow_table[s].value = c.value;
          shadow_table[s].color = c.color;
          r.success = 1'b1;
          done = 1'b1;
        end
      end else begin
        if (shadow_table[s].lock == c.lock && shadow_table[s].color == c.color) begin
          scaled = {24'd0, shadow_table[s].depth} * {24'd0, shadow_scale};
          if (scaled >= {16'd0, c.need}) begin
            r.success = 1'b1;
            r.value = shadow_table[s].value;
          end
          done = 1'b1;
        end else if (shadow_table[s].lock == 32'd0) begin
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Sender: a new command goes on the bus only when the bus is empty or the
  // previous command was transferred at the last rising edge, so in_tvalid
  // never drops and rises again within one step.
  always @(negedge clk) begin
    if (!in_tvalid || in_hs) begin
      if (command_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser <= command_queue[0].op;
        in_tdata <= {6'd0, command_queue[0].need, command_queue[0].color,
                     command_queue[0].depth, command_queue[0].value,
                     command_queue[0].lock, command_queue[0].key};
        command_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here so that the
  // block fills up while the sender keeps offering commands.
  always @(negedge clk) begin
    if (hold_arm && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: every command transfer is predicted at once, every result
  // transfer is checked against the oldest awaited result, and a watchdog
  // watches for a run that has stopped moving.
  always @(posedge clk) begin
    command_t c;
    outcome_t r;
    outcome_t want;
    in_hs <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        shadow_scale <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        c.op = op_t'(in_tuser[0]);
        c.key = in_tdata[31:0];
        c.lock = in_tdata[63:32];
        c.value = in_tdata[79:64];
        c.depth = in_tdata[87:80];
        c.color = in_tdata[89:88];
        c.need = in_tdata[105:90];
        r = probe_table(c);
        awaited_results.push_back(r);
        accepted_count <= accepted_count + 1;
      end
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing awaited: success %0d value %0d",
                 out_tuser[0], $signed(out_tdata));
          fail_count = fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser[0] !== want.success) begin
            $error("success: expected %0d, got %0d", want.success, out_tuser[0]);
            fail_count = fail_count + 1;
          end
          if (out_tdata !== want.value) begin
            $error("result_value: expected %0d, got %0d",
                   $signed(want.value), $signed(out_tdata));
            fail_count = fail_count + 1;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)
          || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_scale(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(posedge clk);
    end while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_command(input op_t op, input logic [31:0] key, input logic [31:0] lock,
                               input logic [15:0] value, input logic [7:0] depth,
                               input logic [1:0] color, input logic [15:0] need);
    command_t c;
    c.op = op;
    c.key = key;
    c.lock = lock;
    c.value = value;
    c.depth = depth;
    c.color = color;
    c.need = need;
    command_queue.push_back(c);
    queued_count = queued_count + 1;
  endtask

  // Random commands crowd a few hot windows, one of them at the top of the
  // home range so the guard slots get used, and draw locks from a small pool
  // so that stores overwrite, windows fill up and lookups find their entries.
  task automatic queue_random(input int unsigned count, input logic [7:0] scale);
    logic [31:0] key;
    logic [31:0] lock;
    logic [15:0] need;
    logic [15:0] home;
    int unsigned pick;
    int unsigned top;
    op_t         op;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0: home = 16'h0000;
        1: home = 16'h1230;
        2: home = 16'h8000;
        default: home = 16'hFFF0;
      endcase
      home = home + 16'($urandom_range(0, 15));
      key = {16'($urandom_range(0, 16'hFFFF)), home};
      if ($urandom_range(0, 9) == 0) begin
        key = $urandom;
      end
      lock = lock_pool[$urandom_range(0, 23)];
      if ($urandom_range(0, 9) == 0) begin
        lock = $urandom;
      end
      op = ($urandom_range(0, 99) < 45) ? OP_STORE : OP_LOOKUP;
      top = 255 * scale;
      if (top > 65535) begin
        top = 65535;
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        need = 16'($urandom_range(0, top));
      end else if (pick < 7) begin
        need = 16'($urandom);
      end else if (pick < 8) begin
        need = '0;
      end else begin
        need = 16'($urandom_range(0, 4 * scale));
      end
      queue_command(op, key, lock, 16'($urandom), 8'($urandom),
                    2'($urandom_range(0, 3)), need);
    end
  endtask

  // Every command queued so far has been transferred and answered, and the
  // block has had time to fall quiet.
  task automatic drain;
    while (accepted_count != queued_count || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      shadow_table[s] = '{32'd0, 8'd0, 16'd0, 2'd0};
    end
    lock_pool[0] = 32'd0;
    lock_pool[1] = 32'hFFFF_FFFF;
    for (int p = 2; p < 24; p++) begin
      lock_pool[p] = $urandom | 32'h0000_0100;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, unit scale, written while the clearing pass runs.
    write_scale(8'd1);
    send_idle_pct = 36;
    recv_idle_pct = 46;
    // Lookups in an empty table: a miss, and a lock zero match on an empty
    // slot of the same colour that needs no depth.
    queue_command(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678, 16'h0000, 8'd0, 2'd0, 16'd0);
    queue_command(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 16'h0000, 8'd0, 2'd0, 16'd0);
    // A store, then hits and misses on depth and a skip on a colour mismatch.
    queue_command(OP_STORE, 32'h0000_0000, 32'hA5A5_0001, 16'h8000, 8'd10, 2'd1, 16'd0);
    queue_command(OP_LOOKUP, 32'hFFFF_0000, 32'hA5A5_0001, 16'h0000, 8'd0, 2'd1, 16'd10);
    queue_command(OP_LOOKUP, 32'h0000_0000, 32'hA5A5_0001, 16'h0000, 8'd0, 2'd1, 16'd11);
    queue_command(OP_LOOKUP, 32'h0000_0000, 32'hA5A5_0001, 16'h0000, 8'd0, 2'd2, 16'd0);
    // Overwrite of an existing lock with another colour.
    queue_command(OP_STORE, 32'h0000_0000, 32'hA5A5_0001, 16'h7FFF, 8'd255, 2'd3, 16'd0);
    queue_command(OP_LOOKUP, 32'h0000_0000, 32'hA5A5_0001, 16'h0000, 8'd0, 2'd3, 16'd255);
    // Fill the rest of the window, then a store that finds no room.
    for (int k = 1; k < PROBES; k++) begin
      queue_command(OP_STORE, 32'h0000_0000, (k == PROBES - 1) ? 32'hFFFF_FFFF : 32'h5A00 + k,
                    16'h0100 + k, 8'(k), 2'(k), 16'd0);
    end
    queue_command(OP_STORE, 32'h0000_0000, 32'hDEAD_BEEF, 16'h1111, 8'd1, 2'd0, 16'd0);
    // Hit on the last slot of a full window, and a miss with no stop at all.
    queue_command(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 8'd0, 2'(PROBES - 1),
                  16'd0);
    queue_command(OP_LOOKUP, 32'h0000_0000, 32'hDEAD_BEEF, 16'h0000, 8'd0, 2'd0, 16'd0);
    // Store with lock zero at the last home slot: it stays empty but visible.
    queue_command(OP_STORE, 32'hFFFF_FFFF, 32'h0000_0000, 16'd77, 8'd5, 2'd2, 16'd0);
    queue_command(OP_LOOKUP, 32'h0000_FFFF, 32'h0000_0000, 16'h0000, 8'd0, 2'd2, 16'd5);
    queue_command(OP_LOOKUP, 32'h0000_FFFF, 32'h0000_0000, 16'h0000, 8'd0, 2'd1, 16'd0);
    queue_command(OP_STORE, 32'hFFFF_FFFF, 32'h0000_0000, 16'd78, 8'd6, 2'd2, 16'd0);
    queue_command(OP_LOOKUP, 32'h0000_FFFF, 32'h0000_0000, 16'h0000, 8'd0, 2'd2, 16'd65535);
    drain();

    // Largest scale: sender idles often, receiver more, with the long hold-off.
    write_scale(8'd255);
    queue_command(OP_LOOKUP, 32'h0000_0000, 32'hA5A5_0001, 16'h0000, 8'd0, 2'd3, 16'd65025);
    queue_command(OP_LOOKUP, 32'h0000_0000, 32'hA5A5_0001, 16'h0000, 8'd0, 2'd3, 16'd65026);
    send_idle_pct = 36;
    recv_idle_pct = 46;
    hold_arm = 1'b1;
    queue_random(600, 8'd255);
    drain();

    // A middling scale with the idling the other way round.
    begin
      logic [7:0] mid;
      mid = 8'($urandom_range(2, 254));
      write_scale(mid);
      send_idle_pct = 46;
      recv_idle_pct = 36;
      queue_random(600, mid);
    end
    drain();

    // Back to the smallest scale, running flat out.
    write_scale(8'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(630, 8'd1);
    drain();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
